// ===== design/tlig_pkg.sv =====
// Package for the terrain LOD index generator: shared codes, state and slot types,
// and the command and status words between controller and datapath.
// Depends on nothing; every other design file imports it.
package tlig_pkg;

    localparam int BLOCK_GRID_DEF = 32;
    localparam int OUT_W = 11;

    localparam logic [2:0] REG_CENTER = 3'd0;
    localparam logic [2:0] REG_LEFT   = 3'd1;
    localparam logic [2:0] REG_TOP    = 3'd2;
    localparam logic [2:0] REG_RIGHT  = 3'd3;
    localparam logic [2:0] REG_BOTTOM = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_WALK,
        ST_IDLE,
        ST_SLOT_A,
        ST_SLOT_B,
        ST_SLOT_C,
        ST_EMPTY
    } state_t;

    typedef enum logic [1:0] {
        SLOT_A,
        SLOT_B,
        SLOT_C
    } slot_t;

    typedef struct packed {
        logic  clr_step;
        logic  walk_step;
        logic  load;
        logic  issue;
        slot_t slot;
        logic  advance;
        logic  emit_empty;
    } cmd_t;

    typedef struct packed {
        logic clr_end;
        logic walk_end;
        logic req_empty;
        logic tri_last;
    } status_t;

endpackage

// ===== design/tlig_ctrl.sv =====
// Controller of the terrain LOD index generator: the state machine that sequences
// the remap clear, the remap walk and the three vertex reads of every triangle.
// Depends on tlig_pkg.
module tlig_ctrl
    import tlig_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t sts,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_end)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = sts.req_empty ? ST_EMPTY : ST_SLOT_A;
                end
            end
            ST_SLOT_A:
            begin
                cmd.issue = 1'b1;
                cmd.slot = SLOT_A;
                state_next = ST_SLOT_B;
            end
            ST_SLOT_B:
            begin
                cmd.issue = 1'b1;
                cmd.slot = SLOT_B;
                state_next = ST_SLOT_C;
            end
            ST_SLOT_C:
            begin
                cmd.issue = 1'b1;
                cmd.slot = SLOT_C;
                if (sts.tri_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_SLOT_A;
                end
            end
            ST_EMPTY:
            begin
                cmd.emit_empty = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== design/tlig_dp.sv =====
// Datapath of the terrain LOD index generator: remap memory with its clear and walk
// counters, request setup, triangle enumeration, vertex read and result registers.
// Depends on tlig_pkg; driven by tlig_ctrl through cmd_t and status_t.
module tlig_dp
    import tlig_pkg::*;
#(
    parameter int BLOCK_GRID = BLOCK_GRID_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          sts,
    input  logic [1:0]       level,
    input  logic [2:0]       region,
    input  logic [1:0]       descend,
    input  logic [4:0]       row,
    input  logic             mapped,
    output logic             valid,
    output logic [OUT_W-1:0] vert_a,
    output logic [OUT_W-1:0] vert_b,
    output logic [OUT_W-1:0] vert_c,
    output logic             last,
    output logic             empty_res
);

    localparam int VP    = BLOCK_GRID + 1;
    localparam int DEPTH = VP * VP;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = AW + 1;
    localparam int CW    = $clog2(BLOCK_GRID + 9);
    localparam int GVP   = BLOCK_GRID * VP;

    // Vertex source codes: base corner (v1 or v2) plus an offset (none, p or p2).
    localparam logic [2:0] V1  = 3'b000;
    localparam logic [2:0] V1P = 3'b001;
    localparam logic [2:0] V1Q = 3'b010;
    localparam logic [2:0] V2  = 3'b100;
    localparam logic [2:0] V2P = 3'b101;
    localparam logic [2:0] V2Q = 3'b110;
    localparam logic [1:0] OFF_P = 2'b01;
    localparam logic [1:0] OFF_Q = 2'b10;

    function automatic logic [8:0] tri_shape(input logic [2:0] kind, input logic [1:0] sub);
        logic [8:0] r;
        r = {V1, V1, V1};
        case (kind)
            REG_LEFT:
                case (sub)
                    2'd0:    r = {V1, V1P, V2};
                    2'd1:    r = {V1P, V2Q, V2};
                    default: r = {V2, V2Q, V2P};
                endcase
            REG_TOP:
                case (sub)
                    2'd0:    r = {V1, V2, V1P};
                    2'd1:    r = {V2, V2Q, V1P};
                    default: r = {V2, V2P, V2Q};
                endcase
            REG_RIGHT:
                case (sub)
                    2'd0:    r = {V1, V2, V1P};
                    2'd1:    r = {V1P, V2, V2Q};
                    default: r = {V2Q, V2, V2P};
                endcase
            REG_BOTTOM:
                case (sub)
                    2'd0:    r = {V1, V2P, V1P};
                    2'd1:    r = {V1, V1Q, V2P};
                    default: r = {V1Q, V2, V2P};
                endcase
            default:
                r = (sub == 2'd0) ? {V1, V1P, V2P} : {V1, V2P, V2};
        endcase
        return r;
    endfunction

    logic [OUT_W-1:0] mem [DEPTH];

    // ---------------- clear and walk ----------------
    logic [AW-1:0]    clr_addr_reg;
    logic [1:0]       wph_reg;
    logic [CW-1:0]    wr_reg;
    logic [CW-1:0]    wc_reg;
    logic             wskip_reg;
    logic [VW-1:0]    wbase_reg;
    logic [OUT_W-1:0] wcnt_reg;

    logic [CW-1:0] ws;
    logic [CW-1:0] wstep;
    logic [CW-1:0] wc_nx;
    logic [CW-1:0] wr_nx;
    logic [VW-1:0] wsvp;
    logic          row_end;
    logic          ph_end;
    logic          skip_nx;

    assign ws      = CW'(4) >> wph_reg;
    assign wsvp    = VW'(4 * VP) >> wph_reg;
    assign wstep   = wskip_reg ? (ws << 1) : ws;
    assign wc_nx   = wc_reg + wstep;
    assign wr_nx   = wr_reg + ws;
    assign row_end = wskip_reg ? (wc_nx >= CW'(BLOCK_GRID)) : (wc_nx > CW'(BLOCK_GRID));
    assign ph_end  = wr_nx > CW'(BLOCK_GRID);
    assign skip_nx = (wph_reg == 2'd0) ? 1'b0 : !wskip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            wph_reg      <= '0;
            wr_reg       <= '0;
            wc_reg       <= '0;
            wskip_reg    <= 1'b0;
            wbase_reg    <= '0;
            wcnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.walk_step)
            begin
                wcnt_reg <= wcnt_reg + OUT_W'(1);
                if (!row_end)
                begin
                    wc_reg <= wc_nx;
                end
                else if (!ph_end)
                begin
                    wr_reg    <= wr_nx;
                    wbase_reg <= wbase_reg + wsvp;
                    wskip_reg <= skip_nx;
                    wc_reg    <= skip_nx ? ws : '0;
                end
                else
                begin
                    wph_reg   <= wph_reg + 2'd1;
                    wr_reg    <= '0;
                    wbase_reg <= '0;
                    wskip_reg <= 1'b1;
                    wc_reg    <= ws >> 1;
                end
            end
        end
    end

    logic [AW-1:0]    mem_waddr;
    logic [OUT_W-1:0] mem_wdata;
    logic             mem_we;

    assign mem_we    = cmd.clr_step || cmd.walk_step;
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : AW'(wbase_reg + VW'(wc_reg));
    assign mem_wdata = cmd.clr_step ? '0 : wcnt_reg;

    // ---------------- request setup ----------------
    logic [1:0]    sh_in;
    logic [2:0]    dsh_in;
    logic [VW-1:0] sv_in;
    logic [VW-1:0] svp_in;
    logic [VW-1:0] ds_in;
    logic [VW-1:0] dsvp_in;
    logic [VW-1:0] hv_in;
    logic [VW-1:0] hvp_in;
    logic [CW-1:0] nq_in;
    logic [CW-1:0] ns_in;
    logic [VW-1:0] rowx;
    logic [VW-1:0] cv1_in;

    logic          set_corner;
    logic [2:0]    set_kind;
    logic [VW-1:0] set_v1;
    logic [VW-1:0] set_stride;
    logic [VW-1:0] set_v2off;
    logic [VW-1:0] set_p;
    logic [VW-1:0] set_p2;
    logic [CW-1:0] set_n;
    logic          legal;
    logic          req_empty_c;

    assign sh_in   = 2'd3 - level;
    assign dsh_in  = 3'(sh_in) + 3'(descend);
    assign sv_in   = VW'(1) << sh_in;
    assign svp_in  = VW'(VP) << sh_in;
    assign ds_in   = VW'(1) << dsh_in;
    assign dsvp_in = VW'(VP) << dsh_in;
    assign hv_in   = ds_in >> 1;
    assign hvp_in  = dsvp_in >> 1;
    assign nq_in   = CW'(BLOCK_GRID >> sh_in) - CW'(2);
    assign ns_in   = CW'(BLOCK_GRID >> dsh_in);
    assign rowx    = VW'(row) + VW'(1);
    assign cv1_in  = (VW'(rowx * VW'(VP)) << sh_in) + sv_in;

    assign legal = (level != 2'd0) && (region <= REG_BOTTOM) && (descend <= 2'd2);

    always_comb
    begin
        req_empty_c = !legal;
        if (region == REG_CENTER)
        begin
            if (descend != 2'd0 || nq_in == '0 || CW'(row) >= nq_in)
            begin
                req_empty_c = 1'b1;
            end
        end
        else if (descend != 2'd0 && level <= descend)
        begin
            req_empty_c = 1'b1;
        end
    end

    always_comb
    begin
        set_corner = 1'b0;
        set_kind   = REG_CENTER;
        set_v1     = cv1_in;
        set_stride = sv_in;
        set_v2off  = svp_in;
        set_p      = sv_in;
        set_p2     = '0;
        set_n      = nq_in;
        if (region != REG_CENTER && descend == 2'd0)
        begin
            // Plain border: two corner triangles, then a run of quads.
            set_corner = 1'b1;
            case (region)
                REG_LEFT:
                begin
                    set_v1     = svp_in;
                    set_stride = svp_in;
                end
                REG_TOP:
                begin
                    set_v1     = sv_in;
                    set_stride = sv_in;
                end
                REG_RIGHT:
                begin
                    set_v1     = svp_in + VW'(BLOCK_GRID) - sv_in;
                    set_stride = svp_in;
                end
                default:
                begin
                    set_v1     = VW'(GVP) - svp_in + sv_in;
                    set_stride = sv_in;
                end
            endcase
        end
        else if (region != REG_CENTER)
        begin
            // Stitched border: a fan of up to three triangles per coarse step.
            set_kind = region;
            set_n    = ns_in;
            case (region)
                REG_LEFT:
                begin
                    set_v1     = '0;
                    set_stride = dsvp_in;
                    set_v2off  = dsvp_in;
                    set_p      = hvp_in + hv_in;
                    set_p2     = hv_in;
                end
                REG_TOP:
                begin
                    set_v1     = '0;
                    set_stride = ds_in;
                    set_v2off  = ds_in;
                    set_p      = hvp_in + hv_in;
                    set_p2     = hvp_in;
                end
                REG_RIGHT:
                begin
                    set_v1     = VW'(BLOCK_GRID);
                    set_stride = dsvp_in;
                    set_v2off  = dsvp_in;
                    set_p      = hvp_in - hv_in;
                    set_p2     = VW'(0) - hv_in;
                end
                default:
                begin
                    set_v1     = VW'(GVP) - hvp_in + hv_in;
                    set_stride = ds_in;
                    set_v2off  = ds_in;
                    set_p      = hvp_in - hv_in;
                    set_p2     = hv_in;
                end
            endcase
        end
    end

    // ---------------- triangle enumeration ----------------
    logic          corner_reg;
    logic          cidx_reg;
    logic [2:0]    kind_reg;
    logic [2:0]    region_reg;
    logic [1:0]    sh_reg;
    logic          mapped_reg;
    logic [VW-1:0] v1_reg;
    logic [VW-1:0] v2_reg;
    logic [VW-1:0] stride_reg;
    logic [VW-1:0] p_reg;
    logic [VW-1:0] p2_reg;
    logic [CW-1:0] nlast_reg;
    logic          nzero_reg;
    logic [CW-1:0] iter_reg;
    logic [1:0]    sub_reg;
    logic          sub_wrap;
    logic          tri_last_c;

    assign sub_wrap = (kind_reg == REG_CENTER) ? (sub_reg == 2'd1) : (sub_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= 1'b0;
            cidx_reg   <= 1'b0;
            iter_reg   <= '0;
            sub_reg    <= '0;
        end
        else if (cmd.load)
        begin
            corner_reg <= set_corner;
            cidx_reg   <= 1'b0;
            iter_reg   <= '0;
            sub_reg    <= '0;
        end
        else if (cmd.advance)
        begin
            if (corner_reg)
            begin
                cidx_reg <= 1'b1;
                if (cidx_reg)
                begin
                    corner_reg <= 1'b0;
                end
            end
            else if (sub_wrap)
            begin
                sub_reg  <= '0;
                iter_reg <= iter_reg + CW'(1);
            end
            else
            begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= set_kind;
            region_reg <= region;
            sh_reg     <= sh_in;
            mapped_reg <= mapped;
            v1_reg     <= set_v1;
            v2_reg     <= set_v1 + set_v2off;
            stride_reg <= set_stride;
            p_reg      <= set_p;
            p2_reg     <= set_p2;
            nlast_reg  <= set_n - CW'(1);
            nzero_reg  <= (set_n == '0);
        end
        else if (cmd.advance && !corner_reg && sub_wrap)
        begin
            v1_reg <= v1_reg + stride_reg;
            v2_reg <= v2_reg + stride_reg;
        end
    end

    always_comb
    begin
        if (corner_reg)
        begin
            tri_last_c = cidx_reg && nzero_reg;
        end
        else if (kind_reg == REG_CENTER)
        begin
            tri_last_c = (iter_reg == nlast_reg) && (sub_reg == 2'd1);
        end
        else
        begin
            tri_last_c = (iter_reg == nlast_reg);
        end
    end

    assign sts = '{
        clr_end:   (clr_addr_reg == AW'(DEPTH - 1)),
        walk_end:  row_end && ph_end && (wph_reg == 2'd2),
        req_empty: req_empty_c,
        tri_last:  tri_last_c
    };

    // Corner triangles of a plain border, written from the grid constants.
    logic [VW-1:0] csv;
    logic [VW-1:0] csvp;
    logic [VW-1:0] ca;
    logic [VW-1:0] cvx [3];
    logic [VW-1:0] corner_v;

    assign csv  = VW'(1) << sh_reg;
    assign csvp = VW'(VP) << sh_reg;

    always_comb
    begin
        ca = '0;
        cvx[0] = '0;
        cvx[1] = '0;
        cvx[2] = '0;
        case (region_reg)
            REG_LEFT:
            begin
                ca = cidx_reg ? VW'(GVP) - csvp : '0;
                cvx[0] = ca;
                cvx[1] = cidx_reg ? ca + csv : csvp + csv;
                cvx[2] = cidx_reg ? ca + csvp : csvp;
            end
            REG_TOP:
            begin
                ca = cidx_reg ? VW'(BLOCK_GRID) - csv : '0;
                cvx[0] = ca;
                cvx[1] = ca + csv;
                cvx[2] = cidx_reg ? ca + csvp : csvp + csv;
            end
            REG_RIGHT:
            begin
                ca = cidx_reg ? VW'(GVP + BLOCK_GRID) - csvp - csv : VW'(BLOCK_GRID);
                cvx[0] = ca;
                cvx[1] = cidx_reg ? ca + csv : ca + csvp;
                cvx[2] = cidx_reg ? ca + csv + csvp : ca + csvp - csv;
            end
            default:
            begin
                ca = cidx_reg ? VW'(GVP + BLOCK_GRID) - csv : VW'(GVP);
                cvx[0] = ca;
                cvx[1] = cidx_reg ? ca - csvp : ca - csvp + csv;
                cvx[2] = ca + csv;
            end
        endcase
    end

    logic [8:0]    shape;
    logic [2:0]    vcode;
    logic [VW-1:0] basev;
    logic [VW-1:0] offv;
    logic [VW-1:0] vert;
    logic          in_range;
    logic [AW-1:0] rd_addr;

    assign shape = tri_shape(kind_reg, sub_reg);

    always_comb
    begin
        unique case (cmd.slot)
            SLOT_A:
            begin
                vcode    = shape[8:6];
                corner_v = cvx[0];
            end
            SLOT_B:
            begin
                vcode    = shape[5:3];
                corner_v = cvx[1];
            end
            SLOT_C:
            begin
                vcode    = shape[2:0];
                corner_v = cvx[2];
            end
            default:
            begin
                vcode    = V1;
                corner_v = cvx[0];
            end
        endcase
    end

    assign basev    = vcode[2] ? v2_reg : v1_reg;
    assign offv     = (vcode[1:0] == OFF_P) ? p_reg :
                      (vcode[1:0] == OFF_Q) ? p2_reg : '0;
    assign vert     = corner_reg ? corner_v : basev + offv;
    assign in_range = vert < VW'(DEPTH);
    assign rd_addr  = in_range ? vert[AW-1:0] : '0;

    // ---------------- memory ----------------
    logic [OUT_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    // ---------------- capture and results ----------------
    logic             cap_vld_reg;
    slot_t            cap_slot_reg;
    logic             cap_last_reg;
    logic             cap_map_reg;
    logic             cap_inr_reg;
    logic [OUT_W-1:0] plain_reg;
    logic [OUT_W-1:0] hold_a_reg;
    logic [OUT_W-1:0] hold_b_reg;
    logic [OUT_W-1:0] capv;
    logic             valid_reg;
    logic [OUT_W-1:0] vert_a_reg;
    logic [OUT_W-1:0] vert_b_reg;
    logic [OUT_W-1:0] vert_c_reg;
    logic             last_reg;
    logic             empty_reg;

    assign capv = cap_map_reg ? (cap_inr_reg ? rd_reg : '0) : plain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_vld_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            cap_vld_reg <= cmd.issue;
            valid_reg   <= (cap_vld_reg && cap_slot_reg == SLOT_C) || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_slot_reg <= cmd.slot;
        cap_last_reg <= sts.tri_last;
        cap_map_reg  <= mapped_reg;
        cap_inr_reg  <= in_range;
        plain_reg    <= OUT_W'(vert);
        if (cmd.emit_empty)
        begin
            vert_a_reg <= '0;
            vert_b_reg <= '0;
            vert_c_reg <= '0;
            last_reg   <= 1'b1;
            empty_reg  <= 1'b1;
        end
        else if (cap_vld_reg)
        begin
            case (cap_slot_reg)
                SLOT_A:  hold_a_reg <= capv;
                SLOT_B:  hold_b_reg <= capv;
                default:
                begin
                    vert_a_reg <= hold_a_reg;
                    vert_b_reg <= hold_b_reg;
                    vert_c_reg <= capv;
                    last_reg   <= cap_last_reg;
                    empty_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign valid     = valid_reg;
    assign vert_a    = vert_a_reg;
    assign vert_b    = vert_b_reg;
    assign vert_c    = vert_c_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;

endmodule

// ===== design/terrain_lod_index_generator.sv =====
// Top level of the terrain LOD index generator: joins controller and datapath.
// Depends on tlig_pkg, tlig_ctrl and tlig_dp.
//
//   word      direction  handshake            ports
//   request   in         start high, busy low level, region, descend, row, mapped
//   triangle  out        valid, one cycle     vert_a, vert_b, vert_c, last, empty_res
//
// After reset the block clears the remap memory, one entry a cycle, and then walks the
// grid to fill it in coarse-to-fine order, one entry a cycle; busy stays high through
// both passes. The three vertices of each triangle are read in turn, in the states
// ST_SLOT_A, ST_SLOT_B and ST_SLOT_C, because the remap memory has a single read
// port; busy stays high while a request's reads are issued, and for an empty request
// while its empty result is emitted. Every result appears on valid for a single cycle
// and the receiver cannot stall it.
module terrain_lod_index_generator
    import tlig_pkg::*;
#(
    parameter int BLOCK_GRID = BLOCK_GRID_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       level,
    input  logic [2:0]       region,
    input  logic [1:0]       descend,
    input  logic [4:0]       row,
    input  logic             mapped,
    output logic             valid,
    output logic [OUT_W-1:0] vert_a,
    output logic [OUT_W-1:0] vert_b,
    output logic [OUT_W-1:0] vert_c,
    output logic             last,
    output logic             empty_res
);

    cmd_t    cmd;
    status_t sts;

    // The controller owns sequencing only; all counters and storage sit in the datapath.
    tlig_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlig_dp #(
        .BLOCK_GRID (BLOCK_GRID)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .level     (level),
        .region    (region),
        .descend   (descend),
        .row       (row),
        .mapped    (mapped),
        .valid     (valid),
        .vert_a    (vert_a),
        .vert_b    (vert_b),
        .vert_c    (vert_c),
        .last      (last),
        .empty_res (empty_res)
    );

`ifndef SYNTHESIS
    // An empty word is always the final one and carries zero vertices.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && empty_res |-> last && vert_a == '0 && vert_b == '0 && vert_c == '0)
        else $error("empty result malformed");

    // A triangle's third vertex read yields a result via cap_vld_reg, then valid_reg.
    a_slot_c_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && cmd.slot == SLOT_C |-> ##2 valid)
        else $error("triangle result missing");

    // Accepting a request always keeps the block busy in the next cycle.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy)
        else $error("busy dropped after load");

    // A triangle result never carries the empty flag.
    a_tri_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && cmd.slot == SLOT_C |-> ##2 !empty_res)
        else $error("triangle flagged empty");
`endif

endmodule

// ===== bench/terrain_lod_index_generator_test.sv =====
// Self-checking bench for terrain_lod_index_generator: requests for every region,
// level and descend go in, and each triangle coming out is checked against a predictor.
// Depends on tlig_pkg and the design files under design/.
module terrain_lod_index_generator_test
    import tlig_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID     = BLOCK_GRID_DEF;
    localparam int PITCH    = GRID + 1;
    localparam int DEPTH    = PITCH * PITCH;
    localparam int MAX_TRIS = 2 * GRID + 4;
    localparam int STALL_LIMIT = 12000;
    localparam int DRAIN_CYCLES = 200;
    localparam int N_RANDOM = 190;

    // One request as the sender holds it. When hold_off is set, the sender
    // waits for every outstanding triangle before offering the word.
    typedef struct {
        logic [1:0] level;
        logic [2:0] region;
        logic [1:0] descend;
        logic [4:0] row;
        logic       mapped;
        bit         hold_off;
    } request_t;

    // One triangle as the block should deliver it.
    typedef struct {
        logic [OUT_W-1:0] a;
        logic [OUT_W-1:0] b;
        logic [OUT_W-1:0] c;
        logic             last;
        logic             empty;
    } triangle_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       level;
    logic [2:0]       region;
    logic [1:0]       descend;
    logic [4:0]       row;
    logic             mapped;
    logic             valid;
    logic [OUT_W-1:0] vert_a;
    logic [OUT_W-1:0] vert_b;
    logic [OUT_W-1:0] vert_c;
    logic             last;
    logic             empty_res;

    request_t  pending_requests[$];
    triangle_t expected_triangles[$];

    // Raw vertex numbers of the request being predicted, before remapping.
    int raw_tris[$][3];

    // Level-ordered vertex numbering, as the block's walk should fill it.
    logic [OUT_W-1:0] level_order[DEPTH];

    int  mismatch_count;
    int  requests_taken;
    int  triangles_seen;
    int  empty_seen;
    int  idle_percent;
    int  quiet_cycles;
    bit  word_taken;

    terrain_lod_index_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .level     (level),
        .region    (region),
        .descend   (descend),
        .row       (row),
        .mapped    (mapped),
        .valid     (valid),
        .vert_a    (vert_a),
        .vert_b    (vert_b),
        .vert_c    (vert_c),
        .last      (last),
        .empty_res (empty_res)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Build the coarse-to-fine numbering: every fourth row and column first,
    // then the vertices that each finer level adds, each pass in row-major order.
    function automatic void build_level_order();
        int count;
        int s;
        bit skip;
        count = 0;
        s = 4;
        for (int i = 0; i < DEPTH; i++)
        begin
            level_order[i] = '0;
        end
        for (int r = 0; r <= GRID; r += s)
        begin
            for (int c = 0; c <= GRID; c += s)
            begin
                level_order[r * PITCH + c] = OUT_W'(count);
                count++;
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            skip = 1'b1;
            s = s / 2;
            for (int r = 0; r <= GRID; r += s)
            begin
                if (skip)
                begin
                    for (int c = s; c < GRID; c += 2 * s)
                    begin
                        level_order[r * PITCH + c] = OUT_W'(count);
                        count++;
                    end
                end
                else
                begin
                    for (int c = 0; c <= GRID; c += s)
                    begin
                        level_order[r * PITCH + c] = OUT_W'(count);
                        count++;
                    end
                end
                skip = !skip;
            end
        end
    endfunction

    function automatic void add_tri(int a, int b, int c);
        if (raw_tris.size() < MAX_TRIS)
        begin
            raw_tris.push_back('{a, b, c});
        end
    endfunction

    // A run of n quads from v1, each quad split into two triangles.
    function automatic void add_quads(int v1, int stride, int n, int s);
        int v2;
        for (int i = 0; i < n; i++)
        begin
            v2 = v1 + PITCH * s;
            add_tri(v1, v1 + s, v2 + s);
            add_tri(v1, v2 + s, v2);
            v1 += stride;
        end
    endfunction

    // Border strip with neighbors at the same level: two corner triangles, then quads.
    function automatic void add_plain_border(logic [2:0] reg_code, int s, int n);
        int a;
        case (reg_code)
            REG_LEFT:
            begin
                add_tri(0, s * PITCH + s, s * PITCH);
                a = (GRID - s) * PITCH;
                add_tri(a, a + s, a + s * PITCH);
                add_quads(PITCH * s, PITCH * s, n, s);
            end
            REG_TOP:
            begin
                add_tri(0, s, s * PITCH + s);
                a = GRID - s;
                add_tri(a, a + s, a + s * PITCH);
                add_quads(s, s, n, s);
            end
            REG_RIGHT:
            begin
                a = GRID;
                add_tri(a, a + s * PITCH, a + s * PITCH - s);
                a = (GRID - s) * PITCH + GRID - s;
                add_tri(a, a + s, a + s + s * PITCH);
                add_quads(PITCH * s + GRID - s, PITCH * s, n, s);
            end
            default:
            begin
                a = GRID * PITCH;
                add_tri(a, a - s * PITCH + s, a + s);
                a = GRID * PITCH + GRID - s;
                add_tri(a, a - s * PITCH, a + s);
                add_quads((GRID - s) * PITCH + s, s, n, s);
            end
        endcase
    endfunction

    // Border stitched to a coarser neighbor: a fan of three triangles per coarse
    // edge segment, the last segment cut to its first triangle.
    function automatic void add_stitched_border(logic [2:0] reg_code, int ds);
        int n;
        int h;
        int v1;
        int v2;
        int p;
        int p2;
        bit fin;
        n = GRID / ds;
        h = ds / 2;
        for (int i = 0; i < n; i++)
        begin
            fin = (i == n - 1);
            case (reg_code)
                REG_LEFT:
                begin
                    p = h * PITCH + h;
                    p2 = h;
                    v1 = i * PITCH * ds;
                    v2 = v1 + PITCH * ds;
                    add_tri(v1, v1 + p, v2);
                    if (!fin)
                    begin
                        add_tri(v1 + p, v2 + p2, v2);
                        add_tri(v2, v2 + p2, v2 + p);
                    end
                end
                REG_TOP:
                begin
                    p = h * PITCH + h;
                    p2 = h * PITCH;
                    v1 = i * ds;
                    v2 = v1 + ds;
                    add_tri(v1, v2, v1 + p);
                    if (!fin)
                    begin
                        add_tri(v2, v2 + p2, v1 + p);
                        add_tri(v2, v2 + p, v2 + p2);
                    end
                end
                REG_RIGHT:
                begin
                    p = h * PITCH - h;
                    p2 = -h;
                    v1 = GRID + i * PITCH * ds;
                    v2 = v1 + PITCH * ds;
                    add_tri(v1, v2, v1 + p);
                    if (!fin)
                    begin
                        add_tri(v1 + p, v2, v2 + p2);
                        add_tri(v2 + p2, v2, v2 + p);
                    end
                end
                default:
                begin
                    p = h * PITCH - h;
                    p2 = h;
                    v1 = (GRID - h) * PITCH + h + i * ds;
                    v2 = v1 + ds;
                    add_tri(v1, v2 + p, v1 + p);
                    if (!fin)
                    begin
                        add_tri(v1, v1 + p2, v2 + p);
                        add_tri(v1 + p2, v2, v2 + p);
                    end
                end
            endcase
        end
    endfunction

    function automatic logic [OUT_W-1:0] vertex_number(int v, logic use_map);
        if (!use_map)
        begin
            return OUT_W'(v);
        end
        if (v >= 0 && v < DEPTH)
        begin
            return level_order[v];
        end
        return '0;
    endfunction

    // Works out the triangle stream of one request and queues it for checking.
    function automatic void predict_triangles(request_t req);
        int s;
        int n;
        int lvl;
        int dsc;
        triangle_t t;
        raw_tris.delete();
        lvl = int'(req.level);
        dsc = int'(req.descend);
        if (lvl >= 1 && req.region <= REG_BOTTOM && dsc <= 2)
        begin
            s = 1 << (3 - lvl);
            n = (GRID - 2 * s) / s;
            if (req.region == REG_CENTER)
            begin
                if (dsc == 0 && n > 0 && int'(req.row) < n)
                begin
                    add_quads(PITCH * (int'(req.row) + 1) * s + s, s, n, s);
                end
            end
            else if (dsc == 0)
            begin
                add_plain_border(req.region, s, n);
            end
            else if (lvl - dsc > 0)
            begin
                add_stitched_border(req.region, s << dsc);
            end
        end
        if (raw_tris.size() == 0)
        begin
            t = '{a: '0, b: '0, c: '0, last: 1'b1, empty: 1'b1};
            expected_triangles.push_back(t);
            return;
        end
        for (int k = 0; k < raw_tris.size(); k++)
        begin
            t.a = vertex_number(raw_tris[k][0], req.mapped);
            t.b = vertex_number(raw_tris[k][1], req.mapped);
            t.c = vertex_number(raw_tris[k][2], req.mapped);
            t.last = (k == raw_tris.size() - 1);
            t.empty = 1'b0;
            expected_triangles.push_back(t);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic add_request(int lv, int rg, int ds, int rw, int mp, bit hold = 1'b0);
        request_t req;
        req.level = 2'(lv);
        req.region = 3'(rg);
        req.descend = 2'(ds);
        req.row = 5'(rw);
        req.mapped = 1'(mp);
        req.hold_off = hold;
        pending_requests.push_back(req);
    endtask

    // Sender: offers the next request at the falling edge and holds it until taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || word_taken))
        begin
            word_taken = 1'b0;
            if (pending_requests.size() != 0
                && !(pending_requests[0].hold_off && expected_triangles.size() != 0)
                && $urandom_range(99) >= idle_percent)
            begin
                level <= pending_requests[0].level;
                region <= pending_requests[0].region;
                descend <= pending_requests[0].descend;
                row <= pending_requests[0].row;
                mapped <= pending_requests[0].mapped;
                start <= 1'b1;
                void'(pending_requests.pop_front());
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Acceptance and checking at the rising edge: a taken request queues its
    // predicted triangles, and each valid triangle is matched to the oldest one.
    always @(posedge clk)
    begin
        triangle_t want;
        if (rst_n)
        begin
            quiet_cycles++;
            if (start && !busy)
            begin
                word_taken = 1'b1;
                requests_taken++;
                quiet_cycles = 0;
                predict_triangles('{level, region, descend, row, mapped, 1'b0});
            end
            if (valid)
            begin
                quiet_cycles = 0;
                triangles_seen++;
                if (empty_res)
                begin
                    empty_seen++;
                end
                if (expected_triangles.size() == 0)
                begin
                    report_mismatch("outstanding triangles", 1, 0);
                end
                else
                begin
                    want = expected_triangles.pop_front();
                    if (vert_a !== want.a)
                    begin
                        report_mismatch("vert_a", vert_a, want.a);
                    end
                    if (vert_b !== want.b)
                    begin
                        report_mismatch("vert_b", vert_b, want.b);
                    end
                    if (vert_c !== want.c)
                    begin
                        report_mismatch("vert_c", vert_c, want.c);
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch("last", last, want.last);
                    end
                    if (empty_res !== want.empty)
                    begin
                        report_mismatch("empty_res", empty_res, want.empty);
                    end
                end
            end
            // The clear and walk passes after reset count as quiet cycles, so the
            // limit is set well above their combined length.
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("terrain_lod_index_generator regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int lv;
        int rg;
        int ds;
        int pick;
        int drained;
        rst_n = 1'b0;
        start = 1'b0;
        level = '0;
        region = '0;
        descend = '0;
        row = '0;
        mapped = 1'b0;
        mismatch_count = 0;
        requests_taken = 0;
        triangles_seen = 0;
        empty_seen = 0;
        idle_percent = 0;
        quiet_cycles = 0;
        word_taken = 1'b0;
        build_level_order();

        // Directed part: every region at the finest level, some mapped and some plain,
        // stitched borders at both depths, and each request that has no stream.
        for (int r = REG_LEFT; r <= REG_BOTTOM; r++)
        begin
            add_request(3, r, 0, 31, r[0]);
            add_request(3, r, 2, 0, 1);
        end
        add_request(1, REG_TOP, 0, 0, 1);
        add_request(2, REG_RIGHT, 1, 5, 0);
        add_request(3, REG_CENTER, 0, 0, 1);
        add_request(3, REG_CENTER, 0, 29, 0);
        add_request(1, REG_CENTER, 0, 5, 1);
        add_request(1, REG_CENTER, 0, 6, 1);      // row past the last quad row
        add_request(0, REG_LEFT, 0, 0, 1);        // level zero
        add_request(2, 7, 0, 0, 1);               // region out of range
        add_request(2, 5, 0, 0, 0);
        add_request(3, REG_TOP, 3, 0, 1);         // descend out of range
        add_request(3, REG_CENTER, 1, 2, 1);      // center with a coarser neighbor
        add_request(1, REG_LEFT, 1, 0, 1);        // descend as deep as the level
        add_request(2, REG_BOTTOM, 2, 31, 1);
        add_request(3, 6, 3, 31, 1, 1'b1);

        // Random part: mostly well-formed requests, a share of out-of-range codes.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(99);
            lv = (pick < 5) ? 0 : $urandom_range(1, 3);
            rg = (pick >= 5 && pick < 10) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            ds = (pick >= 10 && pick < 14) ? 3 : (rg == 0 ? 0 : $urandom_range(0, 2));
            if (pick >= 14 && pick < 20)
            begin
                ds = $urandom_range(1, 2);
            end
            add_request(lv, rg, ds, $urandom_range(0, 31), $urandom_range(0, 1),
                        (i % 60) == 59);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idle phases: none, heavy, moderate, then none again.
        while (pending_requests.size() != 0)
        begin
            @(posedge clk);
            drained = 208 - pending_requests.size();
            case (drained / 52)
                1:       idle_percent = 52;
                2:       idle_percent = 31;
                default: idle_percent = 0;
            endcase
        end
        while (start)
        begin
            @(posedge clk);
        end
        while (expected_triangles.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over all regions, levels and descend depths,",
                 requests_taken);
        $display("checking %0d triangles of which %0d were empty results.",
                 triangles_seen, empty_seen);
        if (mismatch_count == 0 && expected_triangles.size() == 0)
        begin
            $display("terrain_lod_index_generator regression: pass");
        end
        else
        begin
            $display("terrain_lod_index_generator regression: fail");
        end
        $finish;
    end

endmodule

// ===== terrain_lod_index_generator.f =====
design/tlig_pkg.sv
design/tlig_ctrl.sv
design/tlig_dp.sv
design/terrain_lod_index_generator.sv
bench/terrain_lod_index_generator_test.sv
